// File: rtl/ntc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared constants, types and table function for the thermistor converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int unsigned ADC_BITS_DEF        = 10;
  localparam int unsigned LOG_TABLE_DEPTH_DEF = 64;

  localparam int unsigned PRE_W  = 20;
  localparam int unsigned NOM_W  = 8;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned TEMP_W = 17;

  localparam logic [PRE_W-1:0] PRE_RESET = 20'd10000;
  localparam logic [NOM_W-1:0] NOM_RESET = 8'd10;

  typedef enum logic {
    CFG_SERIES_OHMS = 1'b0,
    CFG_NOMINAL_KOHM = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OPEN  = 2'd1,
    ST_SHORT = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  localparam logic [29:0]        LN2_Q30 = 30'd744261118;
  localparam logic signed [35:0] C0_Q24  = 36'sd7392221389;
  localparam logic signed [35:0] C1_Q24  = 36'sd1269918314;
  localparam logic signed [35:0] C2_Q24  = 36'sd70497694;
  localparam logic signed [35:0] C3_Q24  = 36'sd1608264;

  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -17'sd32768;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 17'sd65535;

  typedef struct packed {
    logic valid;
    logic is_open;
    logic is_short;
  } meta_t;

  // log2(1 + k/depth) in Q24, depth = 2^ld, bit by bit squaring
  function automatic logic [24:0] lg_entry(int unsigned k, int unsigned ld);
    logic [63:0] y;
    logic [24:0] r;
    y = 64'(k + (32'd1 << ld)) << (30 - ld);
    r = '0;
    if (y >= (64'd1 << 31)) begin
      r = 25'h1000000;
    end else begin
      for (int i = 0; i < 24; i++) begin
        y = (y * y) >> 30;
        r = {r[23:0], 1'b0};
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          r[0] = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/ntc_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_log2
// Three stage log2 of an unsigned word in Q24: normalize, table, interpolate.
// ----------------------------------------------------------------------------
module ntc_log2 #(
  parameter int unsigned W     = 34,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned LW    = $clog2(W) + 25
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  v_in,
  output logic [LW-1:0] lg_out
);
  import ntc_pkg::*;

  localparam int unsigned PW = $clog2(W);
  localparam int unsigned LD = $clog2(DEPTH);

  logic [24:0] rom_w [0:DEPTH];

  for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
    assign rom_w[k] = lg_entry(k, LD);
  end

  logic [PW-1:0] p_nxt, p_a_r, p_b_r;
  logic [W+29:0] sh;
  logic [29:0]   frac_a_r;
  logic [LD-1:0] idx;
  logic [24:0]   lo_b_r, diff_b_r;
  logic [29:0]   rem_b_r;
  logic [54:0]   prod;
  logic [LW-1:0] lg_nxt, lg_r;

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < W; i++) begin
      if (v_in[i]) p_nxt = PW'(i);
    end
  end

  assign sh   = {v_in, 30'b0} >> p_nxt;
  assign idx  = frac_a_r[29 -: LD];
  assign prod = diff_b_r * rem_b_r;
  assign lg_nxt = LW'({p_b_r, 24'b0}) + LW'(lo_b_r) + LW'(prod[54:30]);

  always_ff @(posedge clk) begin
    if (en) begin
      p_a_r    <= p_nxt;
      frac_a_r <= sh[29:0];
      p_b_r    <= p_a_r;
      lo_b_r   <= rom_w[idx];
      diff_b_r <= rom_w[(LD+1)'(idx) + 1'b1] - rom_w[idx];
      rem_b_r  <= {frac_a_r[29-LD:0], LD'(0)};
      lg_r     <= lg_nxt;
    end
  end

  assign lg_out = lg_r;

endmodule

// File: rtl/ntc_poly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_poly
// Three stage Horner evaluation of the temperature cubic in Q24.
// ----------------------------------------------------------------------------
module ntc_poly #(
  parameter int unsigned XW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  output logic signed [XW+9:0] t_out
);
  import ntc_pkg::*;

  logic signed [XW+35:0] p1;
  logic signed [XW-1:0]  t1_nxt, t1_r, x1_r, x2_r;
  logic signed [2*XW-1:0] p2;
  logic signed [XW+2:0]  t2_nxt, t2_r;
  logic signed [2*XW+2:0] p3;
  logic signed [XW+9:0]  t3_nxt, t3_r;

  assign p1     = C3_Q24 * x_in;
  assign t1_nxt = XW'(C2_Q24 - (p1 >>> 24));
  assign p2     = x1_r * t1_r;
  assign t2_nxt = (XW+3)'((p2 >>> 24) - C1_Q24);
  assign p3     = x2_r * t2_r;
  assign t3_nxt = (XW+10)'((p3 >>> 24) + C0_Q24);

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t1_nxt;
      x1_r <= x_in;
      t2_r <= t2_nxt;
      x2_r <= x1_r;
      t3_r <= t3_nxt;
    end
  end

  assign t_out = t3_r;

endmodule

// File: rtl/ntc_adc_to_temperature.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature
// ADC code of an NTC divider to temperature in Q8 degrees, ten stage pipeline.
//
//   channel | signals                         | direction
//   in      | in_valid, in_stall, in_adc_code | code in
//   out     | out_valid, out_stall, out_*     | temp_q8, status out
//   cfg     | cfg_we, cfg_index, cfg_wdata    | register writes
//
// one code per cycle while the output is not stalled
// the stages are the input products, both log2 pipelines, the log difference, the ln2 scale, the cubic and the output
// a stalled valid output freezes every stage; input stall follows it
// synchronous active low reset clears valid bits and presets the config registers
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature #(
  parameter int unsigned ADC_BITS        = ntc_pkg::ADC_BITS_DEF,
  parameter int unsigned LOG_TABLE_DEPTH = ntc_pkg::LOG_TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ADC_BITS-1:0]              in_adc_code,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ntc_pkg::TEMP_W-1:0] out_temp_q8,
  output logic [1:0]                       out_status,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [ntc_pkg::CFG_W-1:0]        cfg_wdata
);
  import ntc_pkg::*;

  localparam int unsigned NW  = PRE_W + ADC_BITS + 4;
  localparam int unsigned DW  = NOM_W + ADC_BITS;
  localparam int unsigned LWN = $clog2(NW) + 25;
  localparam int unsigned LWD = $clog2(DW) + 25;
  localparam int unsigned LW  = (LWN > LWD) ? LWN : LWD;
  localparam int unsigned XW  = LW + 1;
  localparam int unsigned TW  = XW + 10;
  localparam int unsigned NST = 9;
  localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;

  logic [PRE_W-1:0] pre_r;
  logic [NOM_W-1:0] nom_r;
  logic en;
  meta_t meta_r [0:NST-1];

  logic [PRE_W-1:0]          pre_eff;
  logic [NOM_W-1:0]          nom_eff;
  logic [PRE_W+ADC_BITS-1:0] pc;
  logic [ADC_BITS-1:0]       span;
  logic [NW-1:0]             n_nxt, n_r;
  logic [DW-1:0]             d_nxt, d_r;
  logic [LWN-1:0]            ln_w;
  logic [LWD-1:0]            ld_w;
  logic signed [LW:0]        l_nxt, l_r;
  logic [LW-1:0]             mag;
  logic [LW+29:0]            mprod;
  logic signed [XW-1:0]      x_nxt, x_r;
  logic signed [TW-1:0]      t3;
  logic signed [TW-1:0]      tr;
  logic signed [TW-1:0]      half;
  logic                      out_valid_r;
  logic signed [TEMP_W-1:0]  temp_r, temp_nxt;
  status_t                   status_r, status_nxt;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r <= PRE_RESET;
      nom_r <= NOM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SERIES_OHMS:  pre_r <= cfg_wdata[PRE_W-1:0];
        CFG_NOMINAL_KOHM: nom_r <= cfg_wdata[NOM_W-1:0];
        default: ;
      endcase
    end
  end

  assign pre_eff = (pre_r == '0) ? PRE_W'(1) : pre_r;
  assign nom_eff = (nom_r == '0) ? NOM_W'(1) : nom_r;
  assign pc      = pre_eff * in_adc_code;
  assign n_nxt   = (NW'(pc) << 3) + (NW'(pc) << 1);
  assign span    = FULL_SCALE - in_adc_code;
  assign d_nxt   = nom_eff * span;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) meta_r[i] <= '0;
    end else if (en) begin
      meta_r[0].valid    <= in_valid;
      meta_r[0].is_open  <= &in_adc_code;
      meta_r[0].is_short <= in_adc_code == '0;
      for (int i = 1; i < NST; i++) meta_r[i] <= meta_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_nxt;
      d_r <= d_nxt;
      l_r <= l_nxt;
      x_r <= x_nxt;
    end
  end

  ntc_log2 #(.W(NW), .DEPTH(LOG_TABLE_DEPTH), .LW(LWN)) u_log_n (
    .clk(clk), .en(en), .v_in(n_r), .lg_out(ln_w)
  );

  ntc_log2 #(.W(DW), .DEPTH(LOG_TABLE_DEPTH), .LW(LWD)) u_log_d (
    .clk(clk), .en(en), .v_in(d_r), .lg_out(ld_w)
  );

  assign l_nxt = $signed({1'b0, LW'(ln_w)}) - $signed({1'b0, LW'(ld_w)});
  assign mag   = l_r[LW] ? LW'(-l_r) : l_r[LW-1:0];
  assign mprod = mag * LN2_Q30;
  assign x_nxt = l_r[LW] ? -$signed({1'b0, mprod[LW+29:30]})
                         : $signed({1'b0, mprod[LW+29:30]});

  ntc_poly #(.XW(XW)) u_poly (
    .clk(clk), .en(en), .x_in(x_r), .t_out(t3)
  );

  assign half = TW'(32768);
  assign tr   = (t3 + half) >>> 16;

  always_comb begin
    temp_nxt   = tr[TEMP_W-1:0];
    status_nxt = ST_OK;
    if (meta_r[NST-1].is_open) begin
      temp_nxt   = TEMP_MIN;
      status_nxt = ST_OPEN;
    end else if (meta_r[NST-1].is_short) begin
      temp_nxt   = TEMP_MAX;
      status_nxt = ST_SHORT;
    end else if (tr < TW'(TEMP_MIN)) begin
      temp_nxt   = TEMP_MIN;
      status_nxt = ST_SAT;
    end else if (tr > TW'(TEMP_MAX)) begin
      temp_nxt   = TEMP_MAX;
      status_nxt = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= meta_r[NST-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_r   <= temp_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_temp_q8 = temp_r;
  assign out_status  = status_r;

endmodule

// File: rtl/ntc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_checker
// Port level checks for the thermistor converter, bound to the top level.
// ----------------------------------------------------------------------------
module ntc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [ntc_pkg::TEMP_W-1:0] out_temp_q8,
  input logic [1:0]                        out_status
);
  import ntc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_temp_q8) && $stable(out_status))
    else $error("stalled output changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OPEN |-> out_temp_q8 == TEMP_MIN)
    else $error("open code without minimum temperature");

  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SHORT |-> out_temp_q8 == TEMP_MAX)
    else $error("short code without maximum temperature");

endmodule

bind ntc_adc_to_temperature ntc_checker u_ntc_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_temp_q8(out_temp_q8), .out_status(out_status)
);
